### sv/bwlp_pkg.sv
// ----------------------------------------------------------------------------
// bwlp_pkg
// Types, widths and codes shared by the biquad low-pass controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bwlp_pkg;

    // field and datapath widths
    localparam int DATA_W            = 16;
    localparam int COEF_W            = 32;
    localparam int DELAY_W           = 32;
    localparam int PROD_W            = COEF_W + DELAY_W;
    localparam int ACC_W             = PROD_W + 3;
    localparam int ADDR_W            = 2;
    localparam int FB_SHIFT          = 30;
    localparam int FRAC_BITS_DEFAULT = 14;

    // configuration register indexes
    typedef enum logic [ADDR_W-1:0] {
        REG_ENABLE = 2'd0,
        REG_B0     = 2'd1,
        REG_A1     = 2'd2,
        REG_A2     = 2'd3
    } bwlp_reg_idx_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A1,
        ST_MUL_A2,
        ST_FB_ADD,
        ST_W_CALC,
        ST_MUL_BW,
        ST_MUL_BW1,
        ST_MUL_BW2,
        ST_Y_ADD,
        ST_FINISH,
        ST_BYPASS
    } bwlp_state_t;

    // multiplier operand pairs
    typedef enum logic [2:0] {
        MUL_A1_W1,
        MUL_A2_W2,
        MUL_B0_W,
        MUL_B0_W1,
        MUL_B0_W2
    } bwlp_mul_sel_t;

    // accumulator operations
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_FB,
        ACC_LOAD_Y,
        ACC_ADD,
        ACC_ADD_DBL
    } bwlp_acc_op_t;

    // commands from controller to datapath
    typedef struct packed {
        logic          capture;
        bwlp_mul_sel_t mul_sel;
        bwlp_acc_op_t  acc_op;
        logic          w_load;
        logic          out_load;
        logic          out_bypass;
        logic          delay_shift;
    } bwlp_cmd_t;

endpackage

`default_nettype wire

### sv/bwlp_datapath.sv
// ----------------------------------------------------------------------------
// bwlp_datapath
// Coefficient registers, delay words, shared 32x32 multiplier and accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module bwlp_datapath #(
    parameter int FRAC_BITS = bwlp_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [bwlp_pkg::ADDR_W-1:0]       cfg_addr,
    input  wire logic [bwlp_pkg::COEF_W-1:0]       cfg_wr_data,
    input  wire logic [bwlp_pkg::DATA_W-1:0]       sample_in,
    input  wire bwlp_pkg::bwlp_cmd_t               cmd,
    output logic                                   filter_enable,
    output logic [bwlp_pkg::DATA_W-1:0]            filtered_out
);

    localparam int XS_W    = 38;
    localparam int Y_SHIFT = bwlp_pkg::FB_SHIFT + FRAC_BITS;
    localparam logic signed [bwlp_pkg::ACC_W-1:0] ACC_ONE = 1;
    localparam logic signed [bwlp_pkg::ACC_W-1:0] FB_HALF = ACC_ONE <<< (bwlp_pkg::FB_SHIFT - 1);
    localparam logic signed [bwlp_pkg::ACC_W-1:0] Y_HALF  = ACC_ONE <<< (Y_SHIFT - 1);
    localparam logic signed [bwlp_pkg::ACC_W-1:0] Y_MAX   = 32767;
    localparam logic signed [bwlp_pkg::ACC_W-1:0] Y_MIN   = -32768;

    logic                                    enable_reg;
    logic signed [bwlp_pkg::COEF_W-1:0]      b0_reg, a1_reg, a2_reg;
    logic signed [bwlp_pkg::DELAY_W-1:0]     delay_one_reg, delay_two_reg;
    logic signed [bwlp_pkg::DATA_W-1:0]      x_reg;
    logic signed [bwlp_pkg::DELAY_W-1:0]     w_reg, w_next;
    logic signed [bwlp_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic signed [bwlp_pkg::ACC_W-1:0]       acc_reg, acc_next;
    logic [bwlp_pkg::DATA_W-1:0]             out_data_reg, out_data_next;
    logic signed [bwlp_pkg::COEF_W-1:0]      mul_a;
    logic signed [bwlp_pkg::DELAY_W-1:0]     mul_b;
    logic signed [bwlp_pkg::ACC_W-1:0]       prod_ext, prod_dbl;
    logic signed [bwlp_pkg::ACC_W-1:0]       fb_full, y_full;
    logic signed [XS_W-1:0]                  xs_ext, w_full;
    logic                                    w_ovf;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            b0_reg     <= '0;
            a1_reg     <= '0;
            a2_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                bwlp_pkg::REG_ENABLE: enable_reg <= cfg_wr_data[0];
                bwlp_pkg::REG_B0:     b0_reg     <= cfg_wr_data;
                bwlp_pkg::REG_A1:     a1_reg     <= cfg_wr_data;
                bwlp_pkg::REG_A2:     a2_reg     <= cfg_wr_data;
                default:              ;
            endcase
        end
    end

    assign filter_enable = enable_reg;

    // multiplier operand select
    always_comb begin
        unique case (cmd.mul_sel)
            bwlp_pkg::MUL_A1_W1: begin mul_a = a1_reg; mul_b = delay_one_reg; end
            bwlp_pkg::MUL_A2_W2: begin mul_a = a2_reg; mul_b = delay_two_reg; end
            bwlp_pkg::MUL_B0_W:  begin mul_a = b0_reg; mul_b = w_reg;         end
            bwlp_pkg::MUL_B0_W1: begin mul_a = b0_reg; mul_b = delay_one_reg; end
            bwlp_pkg::MUL_B0_W2: begin mul_a = b0_reg; mul_b = delay_two_reg; end
            default:             begin mul_a = b0_reg; mul_b = w_reg;         end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // accumulator with rounding bias preloaded
    assign prod_ext = {{3{prod_reg[bwlp_pkg::PROD_W-1]}}, prod_reg};
    assign prod_dbl = {{2{prod_reg[bwlp_pkg::PROD_W-1]}}, prod_reg, 1'b0};

    always_comb begin
        unique case (cmd.acc_op)
            bwlp_pkg::ACC_HOLD:    acc_next = acc_reg;
            bwlp_pkg::ACC_LOAD_FB: acc_next = prod_ext + FB_HALF;
            bwlp_pkg::ACC_LOAD_Y:  acc_next = prod_ext + Y_HALF;
            bwlp_pkg::ACC_ADD:     acc_next = acc_reg + prod_ext;
            bwlp_pkg::ACC_ADD_DBL: acc_next = acc_reg + prod_dbl;
            default:               acc_next = acc_reg;
        endcase
    end

    // feedback word with overflow fallback to the scaled sample
    assign xs_ext  = XS_W'(x_reg) <<< FRAC_BITS;
    assign fb_full = acc_reg >>> bwlp_pkg::FB_SHIFT;
    assign w_full  = xs_ext - fb_full[XS_W-1:0];
    assign w_ovf   = (w_full[XS_W-1:bwlp_pkg::DELAY_W-1] != '0) &&
                     (w_full[XS_W-1:bwlp_pkg::DELAY_W-1] != '1);
    assign w_next  = w_ovf ? xs_ext[bwlp_pkg::DELAY_W-1:0] : w_full[bwlp_pkg::DELAY_W-1:0];

    // rounded and saturated result
    assign y_full = acc_reg >>> Y_SHIFT;

    always_comb begin
        if (cmd.out_bypass) begin
            out_data_next = x_reg;
        end else if (y_full > Y_MAX) begin
            out_data_next = Y_MAX[bwlp_pkg::DATA_W-1:0];
        end else if (y_full < Y_MIN) begin
            out_data_next = Y_MIN[bwlp_pkg::DATA_W-1:0];
        end else begin
            out_data_next = y_full[bwlp_pkg::DATA_W-1:0];
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cmd.capture) begin
            x_reg <= sample_in;
        end
        if (cmd.w_load) begin
            w_reg <= w_next;
        end
        if (cmd.out_load) begin
            out_data_reg <= out_data_next;
        end
    end

    // delay line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_one_reg <= '0;
            delay_two_reg <= '0;
        end else if (cmd.delay_shift) begin
            delay_two_reg <= delay_one_reg;
            delay_one_reg <= w_reg;
        end
    end

    assign filtered_out = out_data_reg;

endmodule

`default_nettype wire

### sv/bwlp_ctrl.sv
// ----------------------------------------------------------------------------
// bwlp_ctrl
// Sequencer for one sample: feedback products, feedback word, output products, or pass-through.
// ----------------------------------------------------------------------------
`default_nettype none

module bwlp_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic                 filter_enable,
    output bwlp_pkg::bwlp_cmd_t       cmd
);

    bwlp_pkg::bwlp_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free;

    assign out_free = !out_valid_reg || m_tready;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bwlp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb begin
        unique case (state_reg)
            bwlp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = filter_enable ? bwlp_pkg::ST_MUL_A1 : bwlp_pkg::ST_BYPASS;
                end else begin
                    state_next = bwlp_pkg::ST_IDLE;
                end
            end
            bwlp_pkg::ST_MUL_A1:  state_next = bwlp_pkg::ST_MUL_A2;
            bwlp_pkg::ST_MUL_A2:  state_next = bwlp_pkg::ST_FB_ADD;
            bwlp_pkg::ST_FB_ADD:  state_next = bwlp_pkg::ST_W_CALC;
            bwlp_pkg::ST_W_CALC:  state_next = bwlp_pkg::ST_MUL_BW;
            bwlp_pkg::ST_MUL_BW:  state_next = bwlp_pkg::ST_MUL_BW1;
            bwlp_pkg::ST_MUL_BW1: state_next = bwlp_pkg::ST_MUL_BW2;
            bwlp_pkg::ST_MUL_BW2: state_next = bwlp_pkg::ST_Y_ADD;
            bwlp_pkg::ST_Y_ADD:   state_next = bwlp_pkg::ST_FINISH;
            bwlp_pkg::ST_FINISH,
            bwlp_pkg::ST_BYPASS: begin
                state_next = out_free ? bwlp_pkg::ST_IDLE : state_reg;
            end
            default:              state_next = bwlp_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        cmd             = '0;
        cmd.mul_sel     = bwlp_pkg::MUL_A1_W1;
        cmd.acc_op      = bwlp_pkg::ACC_HOLD;
        unique case (state_reg)
            bwlp_pkg::ST_IDLE:    cmd.capture = s_tvalid;
            bwlp_pkg::ST_MUL_A1:  cmd.mul_sel = bwlp_pkg::MUL_A1_W1;
            bwlp_pkg::ST_MUL_A2: begin
                cmd.mul_sel = bwlp_pkg::MUL_A2_W2;
                cmd.acc_op  = bwlp_pkg::ACC_LOAD_FB;
            end
            bwlp_pkg::ST_FB_ADD:  cmd.acc_op = bwlp_pkg::ACC_ADD;
            bwlp_pkg::ST_W_CALC:  cmd.w_load = 1'b1;
            bwlp_pkg::ST_MUL_BW:  cmd.mul_sel = bwlp_pkg::MUL_B0_W;
            bwlp_pkg::ST_MUL_BW1: begin
                cmd.mul_sel = bwlp_pkg::MUL_B0_W1;
                cmd.acc_op  = bwlp_pkg::ACC_LOAD_Y;
            end
            bwlp_pkg::ST_MUL_BW2: begin
                cmd.mul_sel = bwlp_pkg::MUL_B0_W2;
                cmd.acc_op  = bwlp_pkg::ACC_ADD_DBL;
            end
            bwlp_pkg::ST_Y_ADD:   cmd.acc_op = bwlp_pkg::ACC_ADD;
            bwlp_pkg::ST_FINISH: begin
                cmd.out_load    = out_free;
                cmd.delay_shift = out_free;
            end
            bwlp_pkg::ST_BYPASS: begin
                cmd.out_load   = out_free;
                cmd.out_bypass = 1'b1;
            end
            default:              ;
        endcase
    end

    // output valid tracking
    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign s_tready = (state_reg == bwlp_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load |-> (!out_valid_reg || m_tready)))
        else $error("result overwritten while waiting");

    // delay words move only when a filtered result is delivered to the output register
    a_shift_with_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.delay_shift |-> (cmd.out_load && !cmd.out_bypass)))
        else $error("delay shift without filtered result");

    // an accepted sample starts the filter or the pass-through path
    a_accept_path: assert property (@(posedge aclk) disable iff (!aresetn)
        ((s_tvalid && s_tready) |=>
            ((state_reg == bwlp_pkg::ST_MUL_A1 && $past(filter_enable)) ||
             (state_reg == bwlp_pkg::ST_BYPASS && !$past(filter_enable)))))
        else $error("wrong path after accept");

    // the feedback word is loaded right after the feedback sum completes
    a_w_after_fb: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.w_load |-> ($past(state_reg) == bwlp_pkg::ST_FB_ADD)))
        else $error("feedback word loaded out of sequence");

endmodule

`default_nettype wire

### sv/butterworth_biquad_lowpass_core.sv
// ----------------------------------------------------------------------------
// butterworth_biquad_lowpass_core
// Second-order low-pass biquad, direct form II, one 16-bit sample per request.
// ----------------------------------------------------------------------------
// A filtered sample steps from ST_IDLE through ST_MUL_A1, ST_MUL_A2, ST_FB_ADD,
// ST_W_CALC, ST_MUL_BW, ST_MUL_BW1, ST_MUL_BW2 and ST_Y_ADD to ST_FINISH, where
// its result is loaded; a pass-through sample (filter_enable clear) goes to
// ST_BYPASS and is loaded there. The input accepts the next sample in the cycle
// after the result is loaded, and a finished result waits in its state until the
// previous one leaves on m_tready. The sequence is set by the one shared 32x32
// multiplier, which forms a1*w1, a2*w2, b0*w, b0*w1 and b0*w2 in turn, each
// product registered before it enters the 67-bit accumulator.
// Coefficients must be written via cfg_wr_en/cfg_addr/cfg_wr_data only while
// no sample is in flight, unenforced: index 0 filter_enable, 1 b0, 2 a1, 3 a2 (Q2.30).
`default_nettype none

module butterworth_biquad_lowpass_core #(
    parameter int FRAC_BITS = bwlp_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,     // [15:0] sample_in
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [15:0]                        m_tdata,     // [15:0] filtered_out
    input  wire logic                          cfg_wr_en,
    input  wire logic [bwlp_pkg::ADDR_W-1:0]   cfg_addr,
    input  wire logic [bwlp_pkg::COEF_W-1:0]   cfg_wr_data
);

    bwlp_pkg::bwlp_cmd_t cmd;
    logic                filter_enable;

    // sequencer
    bwlp_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .filter_enable (filter_enable),
        .cmd           (cmd)
    );

    // arithmetic and state
    bwlp_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .sample_in     (s_tdata),
        .cmd           (cmd),
        .filter_enable (filter_enable),
        .filtered_out  (m_tdata)
    );

endmodule

`default_nettype wire
